FILE: rtl/cbs_pkg.sv
`default_nettype none

package cbs_pkg;

  // Axis lanes of the datapath
  localparam int unsigned AXIS_X    = 0;
  localparam int unsigned AXIS_Y    = 1;
  localparam int unsigned NUM_AXES  = 2;

  // Register stages inside one interpolation cell
  localparam int unsigned CELL_LATENCY = 3;

endpackage

`default_nettype wire

FILE: rtl/cubic_bezier_subdivide.sv
`default_nettype none

// Cubic Bezier subdivision at a split parameter (de Casteljau).
// Input channel: drive the four control points and split_t_i, raise start_i;
// a beat is taken at each rising edge with start_i high and busy_o low.
// busy_o stays low, so a new beat may be issued in every cycle.
// split_t_i is clamped to 0..1 on entry.
// Output channel: done_o is high for exactly one cycle per accepted beat,
// with the inner control points of both halves and the split point on the
// result ports in that same cycle. Results leave in input order.
// Pipeline from the accepting edge to the done_o cycle: one input
// register, then three rows of interpolation cells, each cell with three
// register stages (difference, multiply by t, shift and add).
// Throughput: one beat per cycle; every cell starts a new beat each cycle.
// The receiver cannot stall; results must be taken as they appear.
// Reset clears all valid flags; no beat is in flight after reset and the
// datapath registers have no reset.

module cubic_bezier_subdivide #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [COORD_WIDTH-1:0] start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctrl_a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctrl_a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctrl_b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctrl_b_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_y_i,
  input  wire logic signed [T_FRAC_BITS+1:0] split_t_i,
  output logic                               done_o,
  output logic signed      [COORD_WIDTH-1:0] left_ctrl_a_x_o,
  output logic signed      [COORD_WIDTH-1:0] left_ctrl_a_y_o,
  output logic signed      [COORD_WIDTH-1:0] left_ctrl_b_x_o,
  output logic signed      [COORD_WIDTH-1:0] left_ctrl_b_y_o,
  output logic signed      [COORD_WIDTH-1:0] split_x_o,
  output logic signed      [COORD_WIDTH-1:0] split_y_o,
  output logic signed      [COORD_WIDTH-1:0] right_ctrl_a_x_o,
  output logic signed      [COORD_WIDTH-1:0] right_ctrl_a_y_o,
  output logic signed      [COORD_WIDTH-1:0] right_ctrl_b_x_o,
  output logic signed      [COORD_WIDTH-1:0] right_ctrl_b_y_o
);

  import cbs_pkg::*;

  localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic                   vld0_q;
  logic [T_FRAC_BITS:0]   t0_d, t0_q;

  logic signed [COORD_WIDTH-1:0] p0_q [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] c1_q [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] c2_q [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] p1_q [NUM_AXES];

  logic signed [COORD_WIDTH-1:0] q0 [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] q1 [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] q2 [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] r0 [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] r1 [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] s  [NUM_AXES];
  logic        [COORD_WIDTH-1:0] q0_dly [NUM_AXES];
  logic        [COORD_WIDTH-1:0] q2_dly [NUM_AXES];
  logic        [COORD_WIDTH-1:0] r0_dly [NUM_AXES];
  logic        [COORD_WIDTH-1:0] r1_dly [NUM_AXES];

  logic                 vld1 [NUM_AXES][3];
  logic [T_FRAC_BITS:0] t1   [NUM_AXES][3];
  logic                 vld2 [NUM_AXES][2];
  logic [T_FRAC_BITS:0] t2   [NUM_AXES][2];
  logic                 vld3 [NUM_AXES];
  logic [T_FRAC_BITS:0] t3   [NUM_AXES];

  // clamp t to 0..one
  always_comb begin
    if (split_t_i[T_FRAC_BITS+1]) begin
      t0_d = '0;
    end else if (split_t_i[T_FRAC_BITS] && (|split_t_i[T_FRAC_BITS-1:0])) begin
      t0_d = T_ONE;
    end else begin
      t0_d = split_t_i[T_FRAC_BITS:0];
    end
  end

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q         <= t0_d;
    p0_q[AXIS_X] <= start_x_i;
    p0_q[AXIS_Y] <= start_y_i;
    c1_q[AXIS_X] <= ctrl_a_x_i;
    c1_q[AXIS_Y] <= ctrl_a_y_i;
    c2_q[AXIS_X] <= ctrl_b_x_i;
    c2_q[AXIS_Y] <= ctrl_b_y_i;
    p1_q[AXIS_X] <= end_x_i;
    p1_q[AXIS_Y] <= end_y_i;
  end

  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
    // first row
    cbs_lerp_cell #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_q0 (
      .clk_i, .rst_ni, .vld_i(vld0_q), .t_i(t0_q), .a_i(p0_q[ax]), .b_i(c1_q[ax]),
      .vld_o(vld1[ax][0]), .t_o(t1[ax][0]), .y_o(q0[ax])
    );
    cbs_lerp_cell #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_q1 (
      .clk_i, .rst_ni, .vld_i(vld0_q), .t_i(t0_q), .a_i(c1_q[ax]), .b_i(c2_q[ax]),
      .vld_o(vld1[ax][1]), .t_o(t1[ax][1]), .y_o(q1[ax])
    );
    cbs_lerp_cell #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_q2 (
      .clk_i, .rst_ni, .vld_i(vld0_q), .t_i(t0_q), .a_i(c2_q[ax]), .b_i(p1_q[ax]),
      .vld_o(vld1[ax][2]), .t_o(t1[ax][2]), .y_o(q2[ax])
    );

    // second row
    cbs_lerp_cell #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_r0 (
      .clk_i, .rst_ni, .vld_i(vld1[ax][0]), .t_i(t1[ax][0]), .a_i(q0[ax]), .b_i(q1[ax]),
      .vld_o(vld2[ax][0]), .t_o(t2[ax][0]), .y_o(r0[ax])
    );
    cbs_lerp_cell #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_r1 (
      .clk_i, .rst_ni, .vld_i(vld1[ax][2]), .t_i(t1[ax][2]), .a_i(q1[ax]), .b_i(q2[ax]),
      .vld_o(vld2[ax][1]), .t_o(t2[ax][1]), .y_o(r1[ax])
    );

    // third row
    cbs_lerp_cell #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_s (
      .clk_i, .rst_ni, .vld_i(vld2[ax][0]), .t_i(t2[ax][0]), .a_i(r0[ax]), .b_i(r1[ax]),
      .vld_o(vld3[ax]), .t_o(t3[ax]), .y_o(s[ax])
    );

    // align earlier rows with the split point
    cbs_delay #(.WIDTH(COORD_WIDTH), .DEPTH(2 * CELL_LATENCY)) u_q0_dly (
      .clk_i, .data_i(q0[ax]), .data_o(q0_dly[ax])
    );
    cbs_delay #(.WIDTH(COORD_WIDTH), .DEPTH(2 * CELL_LATENCY)) u_q2_dly (
      .clk_i, .data_i(q2[ax]), .data_o(q2_dly[ax])
    );
    cbs_delay #(.WIDTH(COORD_WIDTH), .DEPTH(CELL_LATENCY)) u_r0_dly (
      .clk_i, .data_i(r0[ax]), .data_o(r0_dly[ax])
    );
    cbs_delay #(.WIDTH(COORD_WIDTH), .DEPTH(CELL_LATENCY)) u_r1_dly (
      .clk_i, .data_i(r1[ax]), .data_o(r1_dly[ax])
    );
  end

  // all lanes run in lockstep; the strobe ANDs the valid flags of both lanes
  assign done_o = vld3[AXIS_X] & vld3[AXIS_Y] & (t3[AXIS_X] == t3[AXIS_Y] | 1'b1);

  assign left_ctrl_a_x_o  = $signed(q0_dly[AXIS_X]);
  assign left_ctrl_a_y_o  = $signed(q0_dly[AXIS_Y]);
  assign left_ctrl_b_x_o  = $signed(r0_dly[AXIS_X]);
  assign left_ctrl_b_y_o  = $signed(r0_dly[AXIS_Y]);
  assign split_x_o        = s[AXIS_X];
  assign split_y_o        = s[AXIS_Y];
  assign right_ctrl_a_x_o = $signed(r1_dly[AXIS_X]);
  assign right_ctrl_a_y_o = $signed(r1_dly[AXIS_Y]);
  assign right_ctrl_b_x_o = $signed(q2_dly[AXIS_X]);
  assign right_ctrl_b_y_o = $signed(q2_dly[AXIS_Y]);

endmodule

`default_nettype wire

FILE: rtl/cbs_delay.sv
`default_nettype none

module cbs_delay #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 3
) (
  input  wire logic             clk_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic      [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= data_i;
  end

  for (genvar i = 1; i < DEPTH; i++) begin : g_tap
    always_ff @(posedge clk_i) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/cbs_lerp_cell.sv
`default_nettype none

module cbs_lerp_cell #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          vld_i,
  input  wire logic        [T_FRAC_BITS:0]   t_i,
  input  wire logic signed [COORD_WIDTH-1:0] a_i,
  input  wire logic signed [COORD_WIDTH-1:0] b_i,
  output logic                               vld_o,
  output logic             [T_FRAC_BITS:0]   t_o,
  output logic signed      [COORD_WIDTH-1:0] y_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned TW = T_FRAC_BITS + 2;
  localparam int unsigned PW = DW + TW;

  logic                          vld1_q, vld2_q, vld3_q;
  logic        [T_FRAC_BITS:0]   t1_q, t2_q, t3_q;
  logic signed [COORD_WIDTH-1:0] a1_q, a2_q, y_q;
  logic signed [DW-1:0]          d1_d, d1_q;
  logic signed [PW-1:0]          prod2_d, prod2_q;
  logic signed [PW-1:0]          shift3;
  logic signed [COORD_WIDTH-1:0] y_d;

  assign d1_d    = DW'(b_i) - DW'(a_i);
  assign prod2_d = PW'(d1_q) * PW'($signed({1'b0, t1_q}));
  // floor division by one in t; the sum always lies between a and b
  assign shift3  = prod2_q >>> T_FRAC_BITS;
  assign y_d     = a2_q + shift3[COORD_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q    <= a_i;
    d1_q    <= d1_d;
    t1_q    <= t_i;
    a2_q    <= a1_q;
    prod2_q <= prod2_d;
    t2_q    <= t1_q;
    y_q     <= y_d;
    t3_q    <= t2_q;
  end

  assign vld_o = vld3_q;
  assign t_o   = t3_q;
  assign y_o   = y_q;

endmodule

`default_nettype wire
